### rtl/core/tldmc_pkg.sv
// Package for the two-level direct-mapped cache.
// Holds state and copy-mode types, command codes, register indexes and defaults.
// No dependencies.
package tldmc_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Cost register indexes
    localparam int REG_L1_RD  = 0;
    localparam int REG_L1_WR  = 1;
    localparam int REG_L2_RD  = 2;
    localparam int REG_L2_WR  = 3;
    localparam int REG_MEM_RD = 4;
    localparam int REG_MEM_WR = 5;
    localparam int NUM_REGS   = 6;

    localparam logic [15:0] RST_L1_RD  = 16'd1;
    localparam logic [15:0] RST_L1_WR  = 16'd1;
    localparam logic [15:0] RST_L2_RD  = 16'd10;
    localparam logic [15:0] RST_L2_WR  = 16'd10;
    localparam logic [15:0] RST_MEM_RD = 16'd100;
    localparam logic [15:0] RST_MEM_WR = 16'd100;

    // Default geometry
    localparam int DEF_ADDR_BITS         = 20;
    localparam int DEF_BLOCK_OFFSET_BITS = 6;
    localparam int DEF_NEAR_INDEX_BITS   = 8;
    localparam int DEF_FAR_INDEX_BITS    = 9;

    // Fixed field widths
    localparam int ADDR_IN_W = 20;
    localparam int WORD_W    = 32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_N_CHK,
        ST_F_REQ,
        ST_F_CHK,
        ST_COPY,
        ST_F_DONE,
        ST_N_ACC
    } t_state;

    // The copy mode is kept in its own enum so that the state enum stays at three bits
    typedef enum logic [1:0] {
        CP_N2F,
        CP_F2N,
        CP_F2M,
        CP_M2F
    } t_copy;

endpackage

### rtl/core/tldmc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tldmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write-first is not needed: read returns the old content
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

### rtl/core/two_level_direct_mapped_cache.sv
// Top level of the two-level direct-mapped write-back cache.
// Uses tldmc_pkg and tldmc_ram (near/far line data and tags, backing memory).
//
// One request (read word, write word, clear time) is taken at a time; s_tready is low
// while a request is in work or its result is still waiting. After reset the block zeroes
// all 2^(ADDR_BITS-2) words (262144 by default) of the backing memory and the L2 tags
// before it takes its first request. An L1 hit goes through ST_N_CHK and then ST_N_ACC,
// which registers its result. A miss runs a single 16-word copy sequencer, one word per
// cycle through the RAM ports, with read data registered in the RAMs; it moves each block
// (L1 to L2, L2 to L1, L2 to memory or memory to L2), and every L2 access adds an L2 tag
// lookup and update in ST_F_REQ, ST_F_CHK and ST_F_DONE.
// Clear-time commands, unused commands and out-of-range addresses are answered from ST_IDLE.
// Parameters must keep all tag widths at one bit or more.
module two_level_direct_mapped_cache #(
    parameter int ADDR_BITS         = tldmc_pkg::DEF_ADDR_BITS,
    parameter int BLOCK_OFFSET_BITS = tldmc_pkg::DEF_BLOCK_OFFSET_BITS,
    parameter int NEAR_INDEX_BITS   = tldmc_pkg::DEF_NEAR_INDEX_BITS,
    parameter int FAR_INDEX_BITS    = tldmc_pkg::DEF_FAR_INDEX_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: [19:0] byte_address, [51:20] write_word, rest zero
    input  logic [55:0] s_tdata,
    // request: [1:0] cmd
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // result: [31:0] read_word, [63:32] elapsed_time, [64] range_error, rest zero
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WOB     = BLOCK_OFFSET_BITS - 2;
    localparam int WPB     = 1 << WOB;
    localparam int MEM_W   = ADDR_BITS - 2;
    localparam int BLK_W   = ADDR_BITS - BLOCK_OFFSET_BITS;
    localparam int NTAG_W  = BLK_W - NEAR_INDEX_BITS;
    localparam int FTAG_W  = BLK_W - FAR_INDEX_BITS;
    localparam int NEAR_LINES = 1 << NEAR_INDEX_BITS;
    localparam int NA_W    = NEAR_INDEX_BITS + WOB;
    localparam int FA_W    = FAR_INDEX_BITS + WOB;
    localparam int W       = tldmc_pkg::WORD_W;

    // Registers
    tldmc_pkg::t_state r_state, n_state;
    tldmc_pkg::t_copy  r_copy, n_copy;
    logic [WOB:0]      r_cnt, n_cnt;
    logic [MEM_W-1:0]  r_clr, n_clr;
    logic [MEM_W-1:0]  r_waddr, n_waddr;
    logic              r_wr, n_wr;
    logic [W-1:0]      r_wdata, n_wdata;
    logic [BLK_W-1:0]  r_fblk, n_fblk;
    logic [BLK_W-1:0]  r_mblk, n_mblk;
    logic              r_fwr, n_fwr;
    logic              r_fdirty, n_fdirty;
    logic [NEAR_LINES-1:0] r_nvalid, n_nvalid;
    logic [31:0]       r_time, n_time;
    logic [15:0]       r_cost [tldmc_pkg::NUM_REGS];
    logic              r_ovalid, n_ovalid;
    logic [W-1:0]      r_ord, n_ord;
    logic [31:0]       r_otime, n_otime;
    logic              r_oerr, n_oerr;

    // RAM ports
    logic                    near_we, nm_we, far_we, fm_we, mem_we;
    logic [NA_W-1:0]         near_a;
    logic [NEAR_INDEX_BITS-1:0] nm_a;
    logic [FA_W-1:0]         far_a;
    logic [FAR_INDEX_BITS-1:0]  fm_a;
    logic [MEM_W-1:0]        mem_a;
    logic [W-1:0]            near_wd, near_rd, far_wd, far_rd, mem_wd, mem_rd;
    logic [NTAG_W:0]         nm_wd, nm_rd;
    logic [FTAG_W+1:0]       fm_wd, fm_rd;

    // Field slices
    logic [31:0]       w_a32;
    logic [MEM_W-1:0]  w_in_waddr;
    logic              w_in_err;
    logic [BLK_W-1:0]  w_blk;
    logic [WOB-1:0]    w_woff;
    logic [NEAR_INDEX_BITS-1:0] w_nidx;
    logic [NTAG_W-1:0] w_ntag;
    logic [FAR_INDEX_BITS-1:0]  w_fidx;
    logic [FTAG_W-1:0] w_ftag;
    logic [WOB:0]      w_cm1;
    logic [WOB-1:0]    w_ri, w_wi;
    logic              w_cwe, w_cdone;
    logic              w_fv, w_fd, w_nd;
    logic [FTAG_W-1:0] w_ft;
    logic [NTAG_W-1:0] w_nt;
    logic              w_cfg_we;
    logic [2:0]        w_cfg_idx;

    assign w_a32      = {{(32 - tldmc_pkg::ADDR_IN_W){1'b0}}, s_tdata[19:0]};
    assign w_in_waddr = w_a32[ADDR_BITS-1:2];
    assign w_in_err   = (w_a32 >> ADDR_BITS) != 32'd0;
    assign w_blk      = r_waddr[MEM_W-1:WOB];
    assign w_woff     = r_waddr[WOB-1:0];
    assign w_nidx     = w_blk[NEAR_INDEX_BITS-1:0];
    assign w_ntag     = w_blk[BLK_W-1:NEAR_INDEX_BITS];
    assign w_fidx     = r_fblk[FAR_INDEX_BITS-1:0];
    assign w_ftag     = r_fblk[BLK_W-1:FAR_INDEX_BITS];
    assign w_cm1      = r_cnt - 1'b1;
    assign w_ri       = r_cnt[WOB-1:0];
    assign w_wi       = w_cm1[WOB-1:0];
    assign w_cwe      = r_cnt != '0;
    assign w_cdone    = r_cnt == (WOB+1)'(WPB);
    assign {w_fv, w_fd, w_ft} = fm_rd;
    assign {w_nd, w_nt}       = nm_rd;

    // Configuration port
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_we  = psel & penable & pwrite & pready;
    always_comb begin
        prdata = 32'd0;
        if (32'(w_cfg_idx) < tldmc_pkg::NUM_REGS) begin
            prdata = {16'd0, r_cost[w_cfg_idx]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost[tldmc_pkg::REG_L1_RD]  <= tldmc_pkg::RST_L1_RD;
            r_cost[tldmc_pkg::REG_L1_WR]  <= tldmc_pkg::RST_L1_WR;
            r_cost[tldmc_pkg::REG_L2_RD]  <= tldmc_pkg::RST_L2_RD;
            r_cost[tldmc_pkg::REG_L2_WR]  <= tldmc_pkg::RST_L2_WR;
            r_cost[tldmc_pkg::REG_MEM_RD] <= tldmc_pkg::RST_MEM_RD;
            r_cost[tldmc_pkg::REG_MEM_WR] <= tldmc_pkg::RST_MEM_WR;
        end else if (w_cfg_we && 32'(w_cfg_idx) < tldmc_pkg::NUM_REGS) begin
            r_cost[w_cfg_idx] <= pwdata[15:0];
        end
    end

    // Outputs
    assign s_tready = (r_state == tldmc_pkg::ST_IDLE) && !r_ovalid;
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {7'd0, r_oerr, r_otime, r_ord};

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tldmc_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_nvalid <= '0;
            r_time   <= 32'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_nvalid <= n_nvalid;
            r_time   <= n_time;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_copy   <= n_copy;
        r_cnt    <= n_cnt;
        r_waddr  <= n_waddr;
        r_wr     <= n_wr;
        r_wdata  <= n_wdata;
        r_fblk   <= n_fblk;
        r_mblk   <= n_mblk;
        r_fwr    <= n_fwr;
        r_fdirty <= n_fdirty;
        r_ord    <= n_ord;
        r_otime  <= n_otime;
        r_oerr   <= n_oerr;
    end

    // Next state, RAM ports and result
    always_comb begin
        n_state  = r_state;
        n_copy   = r_copy;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_waddr  = r_waddr;
        n_wr     = r_wr;
        n_wdata  = r_wdata;
        n_fblk   = r_fblk;
        n_mblk   = r_mblk;
        n_fwr    = r_fwr;
        n_fdirty = r_fdirty;
        n_nvalid = r_nvalid;
        n_time   = r_time;
        n_ovalid = r_ovalid && !m_tready;
        n_ord    = r_ord;
        n_otime  = r_otime;
        n_oerr   = r_oerr;

        near_we = 1'b0; near_a = {w_nidx, w_woff}; near_wd = r_wdata;
        nm_we   = 1'b0; nm_a   = w_nidx;           nm_wd   = {1'b0, w_ntag};
        far_we  = 1'b0; far_a  = {w_fidx, w_ri};   far_wd  = near_rd;
        fm_we   = 1'b0; fm_a   = w_fidx;           fm_wd   = {1'b1, r_fwr | r_fdirty, w_ftag};
        mem_we  = 1'b0; mem_a  = {r_mblk, w_ri};   mem_wd  = far_rd;

        unique case (r_state)
            // Zero the backing memory and the L2 tags after reset
            tldmc_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_a  = r_clr;
                mem_wd = '0;
                fm_we  = 1'b1;
                fm_a   = r_clr[FAR_INDEX_BITS-1:0];
                fm_wd  = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == {MEM_W{1'b1}}) begin
                    n_state = tldmc_pkg::ST_IDLE;
                end
            end

            tldmc_pkg::ST_IDLE: begin
                nm_a = w_in_waddr[NA_W-1:WOB];
                if (s_tvalid && s_tready) begin
                    n_ord  = '0;
                    n_oerr = 1'b0;
                    if (s_tuser == tldmc_pkg::CMD_CLEAR) begin
                        n_time   = 32'd0;
                        n_otime  = 32'd0;
                        n_ovalid = 1'b1;
                    end else if (s_tuser != tldmc_pkg::CMD_READ &&
                                 s_tuser != tldmc_pkg::CMD_WRITE) begin
                        n_otime  = r_time;
                        n_ovalid = 1'b1;
                    end else if (w_in_err) begin
                        n_otime  = r_time;
                        n_oerr   = 1'b1;
                        n_ovalid = 1'b1;
                    end else begin
                        n_waddr = w_in_waddr;
                        n_wr    = s_tuser == tldmc_pkg::CMD_WRITE;
                        n_wdata = s_tdata[51:20];
                        n_state = tldmc_pkg::ST_N_CHK;
                    end
                end
            end

            // L1 tag compare; on a miss queue the victim write-back and/or the fill
            tldmc_pkg::ST_N_CHK: begin
                if (r_nvalid[w_nidx] && w_nt == w_ntag) begin
                    n_state = tldmc_pkg::ST_N_ACC;
                end else begin
                    n_state = tldmc_pkg::ST_F_REQ;
                    if (r_nvalid[w_nidx] && w_nd) begin
                        n_fblk = {w_nt, w_nidx};
                        n_fwr  = 1'b1;
                    end else begin
                        n_fblk = w_blk;
                        n_fwr  = 1'b0;
                    end
                end
            end

            // L2 tag read issued by the default port address
            tldmc_pkg::ST_F_REQ: begin
                n_state = tldmc_pkg::ST_F_CHK;
            end

            tldmc_pkg::ST_F_CHK: begin
                n_cnt   = '0;
                n_state = tldmc_pkg::ST_COPY;
                if (w_fv && w_ft == w_ftag) begin
                    n_fdirty = w_fd;
                    n_copy   = r_fwr ? tldmc_pkg::CP_N2F : tldmc_pkg::CP_F2N;
                end else begin
                    n_fdirty = 1'b0;
                    if (w_fv && w_fd) begin
                        n_mblk = {w_ft, w_fidx};
                        n_copy = tldmc_pkg::CP_F2M;
                    end else begin
                        n_mblk = r_fblk;
                        n_copy = tldmc_pkg::CP_M2F;
                    end
                end
            end

            // Shared block mover: read word r_cnt, write word r_cnt-1
            tldmc_pkg::ST_COPY: begin
                n_cnt = r_cnt + 1'b1;
                case (r_copy)
                    tldmc_pkg::CP_N2F: begin
                        near_a = {w_nidx, w_ri};
                        far_we = w_cwe;
                        far_a  = {w_fidx, w_wi};
                        far_wd = near_rd;
                    end
                    tldmc_pkg::CP_F2N: begin
                        far_a   = {w_fidx, w_ri};
                        near_we = w_cwe;
                        near_a  = {w_nidx, w_wi};
                        near_wd = far_rd;
                    end
                    tldmc_pkg::CP_F2M: begin
                        far_a  = {w_fidx, w_ri};
                        mem_we = w_cwe;
                        mem_a  = {r_mblk, w_wi};
                        mem_wd = far_rd;
                    end
                    default: begin
                        mem_a  = {r_mblk, w_ri};
                        far_we = w_cwe;
                        far_a  = {w_fidx, w_wi};
                        far_wd = mem_rd;
                    end
                endcase
                if (w_cdone) begin
                    n_cnt = '0;
                    case (r_copy)
                        tldmc_pkg::CP_F2M: begin
                            n_time = r_time + 32'(r_cost[tldmc_pkg::REG_MEM_WR]);
                            n_mblk = r_fblk;
                            n_copy = tldmc_pkg::CP_M2F;
                        end
                        tldmc_pkg::CP_M2F: begin
                            n_time = r_time + 32'(r_cost[tldmc_pkg::REG_MEM_RD]);
                            n_copy = r_fwr ? tldmc_pkg::CP_N2F : tldmc_pkg::CP_F2N;
                        end
                        tldmc_pkg::CP_N2F: begin
                            n_time  = r_time + 32'(r_cost[tldmc_pkg::REG_L2_WR]);
                            n_state = tldmc_pkg::ST_F_DONE;
                        end
                        default: begin
                            n_time  = r_time + 32'(r_cost[tldmc_pkg::REG_L2_RD]);
                            n_state = tldmc_pkg::ST_F_DONE;
                        end
                    endcase
                end
            end

            // L2 tag update; then either start the fill or finish it at L1
            tldmc_pkg::ST_F_DONE: begin
                fm_we = 1'b1;
                if (r_fwr) begin
                    n_fwr   = 1'b0;
                    n_fblk  = w_blk;
                    n_state = tldmc_pkg::ST_F_REQ;
                end else begin
                    nm_we            = 1'b1;
                    nm_wd            = {1'b0, w_ntag};
                    n_nvalid[w_nidx] = 1'b1;
                    n_state          = tldmc_pkg::ST_N_ACC;
                end
            end

            // L1 word access; read data was fetched in the cycle before
            default: begin
                if (r_wr) begin
                    near_we  = 1'b1;
                    nm_we    = 1'b1;
                    nm_wd    = {1'b1, w_ntag};
                    n_time   = r_time + 32'(r_cost[tldmc_pkg::REG_L1_WR]);
                    n_ord    = '0;
                    n_otime  = n_time;
                    n_oerr   = 1'b0;
                    n_ovalid = 1'b1;
                    n_state  = tldmc_pkg::ST_IDLE;
                end else begin
                    n_time   = r_time + 32'(r_cost[tldmc_pkg::REG_L1_RD]);
                    n_ord    = near_rd;
                    n_otime  = n_time;
                    n_oerr   = 1'b0;
                    n_ovalid = 1'b1;
                    n_state  = tldmc_pkg::ST_IDLE;
                end
            end
        endcase
    end

    tldmc_ram #(.WIDTH(W), .DEPTH(1 << NA_W)) u_near_words (
        .i_clk(i_clk), .i_we(near_we), .i_addr(near_a), .i_wdata(near_wd), .o_rdata(near_rd)
    );
    tldmc_ram #(.WIDTH(NTAG_W + 1), .DEPTH(NEAR_LINES)) u_near_meta (
        .i_clk(i_clk), .i_we(nm_we), .i_addr(nm_a), .i_wdata(nm_wd), .o_rdata(nm_rd)
    );
    tldmc_ram #(.WIDTH(W), .DEPTH(1 << FA_W)) u_far_words (
        .i_clk(i_clk), .i_we(far_we), .i_addr(far_a), .i_wdata(far_wd), .o_rdata(far_rd)
    );
    tldmc_ram #(.WIDTH(FTAG_W + 2), .DEPTH(1 << FAR_INDEX_BITS)) u_far_meta (
        .i_clk(i_clk), .i_we(fm_we), .i_addr(fm_a), .i_wdata(fm_wd), .o_rdata(fm_rd)
    );
    tldmc_ram #(.WIDTH(W), .DEPTH(1 << MEM_W)) u_backing (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_a), .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

endmodule
